[rtl/necir_pkg.sv]
// ----------------------------------------------------------------------------
// necir_pkg
// shared types and constants of the nec infrared frame transmitter
// ----------------------------------------------------------------------------
package necir_pkg;

  localparam int unsigned CfgWidth    = 16;
  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned FrameBits   = 32;
  localparam int unsigned BitIdxWidth = 5;
  localparam int unsigned BitCntWidth = 6;

  localparam logic [CfgWidth-1:0] AgcReset        = 16'd900;
  localparam logic [CfgWidth-1:0] PauseReset      = 16'd450;
  localparam logic [CfgWidth-1:0] MarkReset       = 16'd56;
  localparam logic [CfgWidth-1:0] OneSpaceReset   = 16'd169;
  localparam logic [CfgWidth-1:0] ZeroSpaceReset  = 16'd56;
  localparam logic [CfgWidth-1:0] TrailSpaceReset = 16'd4000;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_AGC         = 3'd0,
    CFG_PAUSE       = 3'd1,
    CFG_MARK        = 3'd2,
    CFG_ONE_SPACE   = 3'd3,
    CFG_ZERO_SPACE  = 3'd4,
    CFG_TRAIL_SPACE = 3'd5
  } cfg_idx_e;

  typedef enum logic [7:0] {
    SEG_IDLE   = 8'b0000_0001,
    SEG_AGC    = 8'b0000_0010,
    SEG_PAUSE  = 8'b0000_0100,
    SEG_MARK   = 8'b0000_1000,
    SEG_SPACE  = 8'b0001_0000,
    SEG_TMARK  = 8'b0010_0000,
    SEG_TSPACE = 8'b0100_0000,
    SEG_EXTRA  = 8'b1000_0000
  } seg_e;

  typedef struct packed {
    logic [CfgWidth-1:0] agc;
    logic [CfgWidth-1:0] pause;
    logic [CfgWidth-1:0] mark;
    logic [CfgWidth-1:0] one_space;
    logic [CfgWidth-1:0] zero_space;
    logic [CfgWidth-1:0] trail_space;
  } cfg_t;

endpackage

[rtl/necir_cfg.sv]
// ----------------------------------------------------------------------------
// necir_cfg
// timing register file, written through a plain write port
// ----------------------------------------------------------------------------
module necir_cfg
  import necir_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [CfgWidth-1:0]    cfg_data_i,
  output cfg_t                   cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_AGC:         cfg_d.agc         = cfg_data_i;
        CFG_PAUSE:       cfg_d.pause       = cfg_data_i;
        CFG_MARK:        cfg_d.mark        = cfg_data_i;
        CFG_ONE_SPACE:   cfg_d.one_space   = cfg_data_i;
        CFG_ZERO_SPACE:  cfg_d.zero_space  = cfg_data_i;
        CFG_TRAIL_SPACE: cfg_d.trail_space = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.agc         <= AgcReset;
      cfg_q.pause       <= PauseReset;
      cfg_q.mark        <= MarkReset;
      cfg_q.one_space   <= OneSpaceReset;
      cfg_q.zero_space  <= ZeroSpaceReset;
      cfg_q.trail_space <= TrailSpaceReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/necir_seg.sv]
// ----------------------------------------------------------------------------
// necir_seg
// finds the first segment of non-zero length from the current position
// ----------------------------------------------------------------------------
module necir_seg
  import necir_pkg::*;
#(
  parameter int unsigned DurationWidth = 16
) (
  input  seg_e                     seg_i,
  input  logic [BitCntWidth-1:0]   bit_i,
  input  logic [FrameBits-1:0]     frame_i,
  input  cfg_t                     cfg_i,
  output seg_e                     seg_o,
  output logic [BitCntWidth-1:0]   bit_o,
  output logic [DurationWidth-1:0] len_o
);

  logic [DurationWidth-1:0] agc_len, pause_len, mark_len;
  logic [DurationWidth-1:0] one_len, zero_len, trail_len;
  logic                     agc_nz, pause_nz, mark_nz, one_nz, zero_nz, trail_nz;
  logic [FrameBits-1:0]     space_nz;
  logic [FrameBits-1:0]     search_vec;
  logic [BitCntWidth-1:0]   bit_next;
  logic [BitCntWidth-1:0]   search_start;
  logic [BitIdxWidth-1:0]   first_idx;
  logic                     found;
  seg_e                     tail_seg;
  seg_e                     run_seg;
  logic [BitCntWidth-1:0]   run_bit;

  assign agc_len   = DurationWidth'(cfg_i.agc);
  assign pause_len = DurationWidth'(cfg_i.pause);
  assign mark_len  = DurationWidth'(cfg_i.mark);
  assign one_len   = DurationWidth'(cfg_i.one_space);
  assign zero_len  = DurationWidth'(cfg_i.zero_space);
  assign trail_len = DurationWidth'(cfg_i.trail_space);

  assign agc_nz   = |agc_len;
  assign pause_nz = |pause_len;
  assign mark_nz  = |mark_len;
  assign one_nz   = |one_len;
  assign zero_nz  = |zero_len;
  assign trail_nz = |trail_len;

  assign bit_next     = bit_i + BitCntWidth'(1);
  assign search_start = (seg_i == SEG_SPACE) ? bit_next : bit_i;

  // bits whose space segment would drive at least one sample
  always_comb begin
    for (int i = 0; i < FrameBits; i++) begin
      space_nz[i] = frame_i[i] ? one_nz : zero_nz;
    end
  end

  assign search_vec = space_nz & ({FrameBits{1'b1}} << search_start[BitIdxWidth-1:0]);
  assign found      = |search_vec;

  always_comb begin
    first_idx = '0;
    for (int i = FrameBits - 1; i >= 0; i--) begin
      if (search_vec[i]) begin
        first_idx = BitIdxWidth'(i);
      end
    end
  end

  always_comb begin
    if (mark_nz) begin
      tail_seg = SEG_TMARK;
    end else if (trail_nz) begin
      tail_seg = SEG_TSPACE;
    end else begin
      tail_seg = SEG_EXTRA;
    end
  end

  // entry into the bit section: the mark of the current bit, else the first space of non-zero length, else the tail
  always_comb begin
    if (mark_nz) begin
      run_seg = SEG_MARK;
      run_bit = bit_i;
    end else if (found) begin
      run_seg = SEG_SPACE;
      run_bit = {1'b0, first_idx};
    end else begin
      run_seg = tail_seg;
      run_bit = BitCntWidth'(FrameBits);
    end
  end

  always_comb begin
    seg_o = seg_i;
    bit_o = bit_i;
    unique case (seg_i)
      SEG_AGC: begin
        if (agc_nz) begin
          seg_o = SEG_AGC;
        end else if (pause_nz) begin
          seg_o = SEG_PAUSE;
        end else begin
          seg_o = run_seg;
          bit_o = run_bit;
        end
      end
      SEG_PAUSE: begin
        if (!pause_nz) begin
          seg_o = run_seg;
          bit_o = run_bit;
        end
      end
      SEG_MARK: begin
        seg_o = run_seg;
        bit_o = run_bit;
      end
      SEG_SPACE: begin
        if (space_nz[bit_i[BitIdxWidth-1:0]]) begin
          seg_o = SEG_SPACE;
        end else if (bit_next >= BitCntWidth'(FrameBits)) begin
          seg_o = tail_seg;
          bit_o = bit_next;
        end else if (mark_nz) begin
          seg_o = SEG_MARK;
          bit_o = bit_next;
        end else if (found) begin
          seg_o = SEG_SPACE;
          bit_o = {1'b0, first_idx};
        end else begin
          seg_o = tail_seg;
          bit_o = BitCntWidth'(FrameBits);
        end
      end
      SEG_TMARK:  seg_o = tail_seg;
      SEG_TSPACE: seg_o = trail_nz ? SEG_TSPACE : SEG_EXTRA;
      SEG_EXTRA:  seg_o = SEG_EXTRA;
      default:    seg_o = SEG_IDLE;
    endcase
  end

  always_comb begin
    unique case (seg_o)
      SEG_AGC:    len_o = agc_len;
      SEG_PAUSE:  len_o = pause_len;
      SEG_MARK:   len_o = mark_len;
      SEG_SPACE:  len_o = frame_i[bit_o[BitIdxWidth-1:0]] ? one_len : zero_len;
      SEG_TMARK:  len_o = mark_len;
      SEG_TSPACE: len_o = trail_len;
      SEG_EXTRA:  len_o = DurationWidth'(1);
      default:    len_o = '0;
    endcase
  end

endmodule

[rtl/nec_ir_frame_transmitter.sv]
// ----------------------------------------------------------------------------
// nec_ir_frame_transmitter
// nec infrared frame sequencer, one level sample per tick request
// ----------------------------------------------------------------------------
// One request can be taken in each cycle while the output register is free or
// being emptied; its result sits in the output register from the next cycle
// on. A send request (tuser high) loads address, ~address, data and ~data and
// restarts the frame; each tick request returns one pin level sample, and the
// tick that finds the frame finished is marked by tlast. Segments of zero
// length are skipped within the same tick. The next request is taken while a
// result waits downstream, as long as the output register is free or being
// emptied.
// ----------------------------------------------------------------------------
module nec_ir_frame_transmitter
  import necir_pkg::*;
#(
  parameter int unsigned DurationWidth = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [CfgWidth-1:0]    cfg_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [15:0]            s_axis_tdata,  // address, payload
  input  logic                   s_axis_tuser,  // command
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [7:0]             m_axis_tdata,  // pin_level, busy_res, zero pad
  output logic                   m_axis_tlast
);

  cfg_t                     cfg;
  seg_e                     seg_q, seg_d, res_seg;
  logic [BitCntWidth-1:0]   bit_q, bit_d, res_bit, bit_inc;
  logic [DurationWidth-1:0] tick_q, tick_d, res_len, tick_base;
  logic [DurationWidth:0]   tick_inc;
  logic [FrameBits-1:0]     frame_q, frame_d;
  logic                     sending_q, sending_d;
  logic                     m_valid_q, m_valid_d;
  logic [2:0]               m_res_q, m_res_d;
  logic                     accept;
  logic [7:0]               addr, data;

  necir_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  necir_seg #(
    .DurationWidth (DurationWidth)
  ) u_seg (
    .seg_i   (seg_q),
    .bit_i   (bit_q),
    .frame_i (frame_q),
    .cfg_i   (cfg),
    .seg_o   (res_seg),
    .bit_o   (res_bit),
    .len_o   (res_len)
  );

  assign s_axis_tready = ~m_valid_q | m_axis_tready;
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign addr          = s_axis_tdata[7:0];
  assign data          = s_axis_tdata[15:8];

  // a skipped segment starts its count afresh
  assign tick_base = (res_seg != seg_q || res_bit != bit_q) ? '0 : tick_q;
  assign tick_inc  = {1'b0, tick_base} + (DurationWidth+1)'(1);
  assign bit_inc   = res_bit + BitCntWidth'(1);

  always_comb begin
    seg_d     = seg_q;
    bit_d     = bit_q;
    tick_d    = tick_q;
    frame_d   = frame_q;
    sending_d = sending_q;
    m_res_d   = m_res_q;
    m_valid_d = m_valid_q & ~m_axis_tready;
    if (accept) begin
      m_valid_d = 1'b1;
      m_res_d   = '0;
      if (s_axis_tuser) begin
        frame_d   = {~data, data, ~addr, addr};
        seg_d     = SEG_AGC;
        bit_d     = '0;
        tick_d    = '0;
        sending_d = 1'b1;
        m_res_d   = 3'b010;
      end else if (sending_q) begin
        if (res_seg == SEG_IDLE) begin
          sending_d = 1'b0;
          seg_d     = SEG_IDLE;
          m_res_d   = 3'b100;
        end else begin
          m_res_d[0] = (res_seg == SEG_AGC) || (res_seg == SEG_MARK) ||
                       (res_seg == SEG_TMARK);
          m_res_d[1] = 1'b1;
          bit_d      = res_bit;
          if (tick_inc >= {1'b0, res_len}) begin
            tick_d = '0;
            unique case (res_seg)
              SEG_AGC:    seg_d = SEG_PAUSE;
              SEG_PAUSE:  seg_d = SEG_MARK;
              SEG_MARK:   seg_d = SEG_SPACE;
              SEG_SPACE: begin
                bit_d = bit_inc;
                seg_d = (bit_inc >= BitCntWidth'(FrameBits)) ? SEG_TMARK : SEG_MARK;
              end
              SEG_TMARK:  seg_d = SEG_TSPACE;
              SEG_TSPACE: seg_d = SEG_EXTRA;
              default:    seg_d = SEG_IDLE;
            endcase
          end else begin
            seg_d  = res_seg;
            tick_d = tick_inc[DurationWidth-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q     <= SEG_IDLE;
      bit_q     <= '0;
      tick_q    <= '0;
      frame_q   <= '0;
      sending_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      seg_q     <= seg_d;
      bit_q     <= bit_d;
      tick_q    <= tick_d;
      frame_q   <= frame_d;
      sending_q <= sending_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_res_q <= m_res_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'b0, m_res_q[1:0]};
  assign m_axis_tlast  = m_res_q[2];

endmodule

[bench/nec_ir_frame_transmitter_tb.sv]
// ----------------------------------------------------------------------------
// nec_ir_frame_transmitter_tb
// self-checking bench for the nec infrared frame transmitter
// ----------------------------------------------------------------------------
// Send and tick requests go in on the slave stream and level samples come out
// on the master stream. A scoreboard class tracks the frame sequencer on its
// own and checks every sample field by field. The run starts with the reset
// timings, cut short by clearing them in the middle of a frame, then all-zero
// timings, a few tight hand-picked frames and a longer agc burst. After that
// come random timing sets, each with random frames that are sometimes
// restarted. Both stream sides stall at random, except in stretches where
// they run flat out.
// ----------------------------------------------------------------------------
module nec_ir_frame_transmitter_tb;
  import necir_pkg::*;

  localparam bit CmdTick = 1'b0;
  localparam bit CmdSend = 1'b1;
  localparam logic [CfgIdxWidth-1:0] CfgIdxSpare = 3'd7;
  localparam int unsigned RandomItems = 700;
  localparam int unsigned TimeoutCycles = 2_000_000;

  typedef struct packed {
    logic pin;
    logic busy;
    logic done;
  } level_t;

  class nec_level_board;
    cfg_t                 timing;
    logic [31:0]          frame_bits;
    seg_e                 seg;
    logic [BitCntWidth-1:0] bit_cnt;
    int unsigned          tick_cnt;
    bit                   sending;
    level_t               want_levels[$];
    int unsigned          n_mismatch;

    function new();
      timing = '{agc: AgcReset, pause: PauseReset, mark: MarkReset,
                 one_space: OneSpaceReset, zero_space: ZeroSpaceReset,
                 trail_space: TrailSpaceReset};
      frame_bits = '0;
      seg        = SEG_IDLE;
      bit_cnt    = '0;
      tick_cnt   = 0;
      sending    = 1'b0;
      n_mismatch = 0;
    endfunction

    function void set_reg(logic [CfgIdxWidth-1:0] idx, logic [CfgWidth-1:0] value);
      case (idx)
        CFG_AGC:         timing.agc = value;
        CFG_PAUSE:       timing.pause = value;
        CFG_MARK:        timing.mark = value;
        CFG_ONE_SPACE:   timing.one_space = value;
        CFG_ZERO_SPACE:  timing.zero_space = value;
        CFG_TRAIL_SPACE: timing.trail_space = value;
        default: ;
      endcase
    endfunction

    function int unsigned seg_len();
      case (seg)
        SEG_AGC:    return 32'(timing.agc);
        SEG_PAUSE:  return 32'(timing.pause);
        SEG_MARK:   return 32'(timing.mark);
        SEG_SPACE:  return frame_bits[bit_cnt[BitIdxWidth-1:0]] ? 32'(timing.one_space)
                                                                 : 32'(timing.zero_space);
        SEG_TMARK:  return 32'(timing.mark);
        SEG_TSPACE: return 32'(timing.trail_space);
        SEG_EXTRA:  return 1;
        default:    return 0;
      endcase
    endfunction

    function void next_seg();
      tick_cnt = 0;
      case (seg)
        SEG_AGC:    seg = SEG_PAUSE;
        SEG_PAUSE:  seg = SEG_MARK;
        SEG_MARK:   seg = SEG_SPACE;
        SEG_SPACE: begin
          bit_cnt = bit_cnt + BitCntWidth'(1);
          seg = (bit_cnt >= BitCntWidth'(FrameBits)) ? SEG_TMARK : SEG_MARK;
        end
        SEG_TMARK:  seg = SEG_TSPACE;
        SEG_TSPACE: seg = SEG_EXTRA;
        default:    seg = SEG_IDLE;
      endcase
    endfunction

    function void take_request(bit cmd, logic [7:0] addr, logic [7:0] data);
      level_t      lvl;
      int unsigned len;
      lvl = '0;
      if (cmd == CmdSend) begin
        frame_bits = {~data, data, ~addr, addr};
        seg        = SEG_AGC;
        bit_cnt    = '0;
        tick_cnt   = 0;
        sending    = 1'b1;
        lvl.busy   = 1'b1;
      end else if (sending) begin
        len = seg_len();
        while (len == 0 && seg != SEG_IDLE) begin
          next_seg();
          len = seg_len();
        end
        if (seg == SEG_IDLE) begin
          sending  = 1'b0;
          lvl.done = 1'b1;
        end else begin
          lvl.pin  = (seg == SEG_AGC || seg == SEG_MARK || seg == SEG_TMARK);
          lvl.busy = 1'b1;
          tick_cnt++;
          if (tick_cnt >= len) next_seg();
        end
      end
      want_levels.push_back(lvl);
    endfunction

    function void check_sample(logic [7:0] sample, logic last);
      level_t lvl;
      if (want_levels.size() == 0) begin
        $error("unexpected sample %h", sample);
        n_mismatch++;
        return;
      end
      lvl = want_levels.pop_front();
      if (sample[0] !== lvl.pin) begin
        $error("pin_level: expected %0d, got %0d", lvl.pin, sample[0]);
        n_mismatch++;
      end
      if (sample[1] !== lvl.busy) begin
        $error("busy_res: expected %0d, got %0d", lvl.busy, sample[1]);
        n_mismatch++;
      end
      if (last !== lvl.done) begin
        $error("done_res: expected %0d, got %0d", lvl.done, last);
        n_mismatch++;
      end
      if (sample[7:2] !== 6'd0) begin
        $error("pad: expected 0, got %0d", sample[7:2]);
        n_mismatch++;
      end
    endfunction

    function int unsigned pending();
      return want_levels.size();
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CfgIdxWidth-1:0] cfg_idx_i;
  logic [CfgWidth-1:0]    cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [15:0]            s_axis_tdata;  // address, payload
  logic                   s_axis_tuser;  // command
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [7:0]             m_axis_tdata;  // pin_level, busy_res, zero pad
  logic                   m_axis_tlast;

  nec_level_board board = new();
  bit             idle_en = 1'b1;

  nec_ir_frame_transmitter DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // sample sink with random back-pressure
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        board.check_sample(m_axis_tdata, m_axis_tlast);
      end
      m_axis_tready <= idle_en ? ($urandom_range(99) >= 33) : 1'b1;
    end
  end

  task automatic push_request(bit cmd, logic [7:0] addr, logic [7:0] data);
    while (idle_en && $urandom_range(99) < 33) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {data, addr};
    do @(posedge clk_i); while (!s_axis_tready);
    board.take_request(cmd, addr, data);
  endtask

  task automatic push_tick();
    push_request(CmdTick, 8'($urandom), 8'($urandom));
  endtask

  task automatic push_send();
    push_request(CmdSend, 8'($urandom), 8'($urandom));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
  endtask

  task automatic settle_frame();
    while (board.sending) push_tick();
    drain();
  endtask

  task automatic reg_write(logic [CfgIdxWidth-1:0] idx, logic [CfgWidth-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    board.set_reg(idx, value);
  endtask

  task automatic load_timing(cfg_t t, bit poke_spare);
    drain();
    reg_write(CFG_AGC, t.agc);
    reg_write(CFG_PAUSE, t.pause);
    reg_write(CFG_MARK, t.mark);
    reg_write(CFG_ONE_SPACE, t.one_space);
    reg_write(CFG_ZERO_SPACE, t.zero_space);
    reg_write(CFG_TRAIL_SPACE, t.trail_space);
    if (poke_spare) reg_write(CfgIdxSpare, '1);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [CfgWidth-1:0] rand_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return '0;
    if (r < 90) return CfgWidth'($urandom_range(1, 4));
    return CfgWidth'($urandom_range(5, 24));
  endfunction

  function automatic cfg_t rand_timing();
    return '{agc: rand_len(), pause: rand_len(), mark: rand_len(),
             one_space: rand_len(), zero_space: rand_len(), trail_space: rand_len()};
  endfunction

  initial begin
    int unsigned n_random;
    int unsigned n_set;
    int unsigned r;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= '0;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tuser  <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset timings: idle tick, send, restart mid-frame, part of the agc burst
    push_tick();
    push_request(CmdSend, 8'hA5, 8'h3C);
    repeat (5) push_tick();
    push_request(CmdSend, 8'hFF, 8'h00);
    repeat (12) push_tick();

    // all segments emptied mid-frame, spare register index must be ignored
    load_timing('{agc: '0, pause: '0, mark: '0, one_space: '0, zero_space: '0,
                  trail_space: '0}, 1'b1);
    repeat (2) push_tick();
    push_request(CmdSend, 8'h00, 8'hFF);
    push_request(CmdSend, 8'hFF, 8'h00);
    repeat (3) push_tick();

    // tight frames, no stalls
    idle_en = 1'b0;
    load_timing('{agc: 16'd2, pause: 16'd1, mark: 16'd1, one_space: 16'd3,
                  zero_space: 16'd1, trail_space: 16'd2}, 1'b0);
    push_request(CmdSend, 8'h00, 8'hFF);
    settle_frame();
    push_request(CmdSend, 8'h5A, 8'hC3);
    settle_frame();
    idle_en = 1'b1;

    // zero-length bits and no agc
    load_timing('{agc: '0, pause: 16'd1, mark: '0, one_space: 16'd2, zero_space: '0,
                  trail_space: 16'd1}, 1'b0);
    push_request(CmdSend, 8'h81, 8'h7E);
    settle_frame();

    // longer agc burst and trailing space
    load_timing('{agc: 16'd100, pause: 16'd1, mark: 16'd1, one_space: 16'd1,
                  zero_space: '0, trail_space: 16'd60}, 1'b0);
    push_request(CmdSend, 8'hF0, 8'h0F);
    settle_frame();

    n_random = 0;
    n_set    = 0;
    while (n_random < RandomItems) begin
      idle_en = (n_set % 4 != 1);
      load_timing(rand_timing(), 1'b0);
      n_set++;
      repeat ($urandom_range(1, 3)) begin
        push_send();
        n_random++;
        while (board.sending) begin
          r = $urandom_range(999);
          if (r < 3) begin
            push_send();
            n_random++;
          end else if (r < 8) begin
            drain();
          end else begin
            push_tick();
            n_random++;
          end
        end
        repeat ($urandom_range(0, 2)) begin
          push_tick();
          n_random++;
        end
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (board.n_mismatch == 0 && board.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #(8 * TimeoutCycles);
    $display("tb: failure");
    $finish;
  end

endmodule

[files.f]
rtl/necir_pkg.sv
rtl/necir_cfg.sv
rtl/necir_seg.sv
rtl/nec_ir_frame_transmitter.sv
bench/nec_ir_frame_transmitter_tb.sv
